@@ hdl/simon_pkg.sv @@
package simon_pkg;

    localparam int NUM_ROUNDS = 68;
    localparam int WORD_W     = 64;
    localparam int RND_W      = $clog2(NUM_ROUNDS);
    localparam int Z_LEN      = 62;
    localparam int Z_W        = $clog2(Z_LEN);
    localparam int CFG_IDX_W  = 2;

    // constant sequence z2, bit j of the sequence at bit j
    localparam logic [Z_LEN-1:0] Z2 =
        62'b110011_01101001_11111000_10000101_00011001_00101100_00001110_11110101;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [RND_W-1:0]  t_rnd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD0 = 2'd0,
        REG_KEY_WORD1 = 2'd1
    } t_cfg_reg;

    function automatic t_word rotl(input t_word v, input int unsigned s);
        rotl = (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic t_word rotr(input t_word v, input int unsigned s);
        rotr = (v >> s) | (v << (WORD_W - s));
    endfunction

    // k[i] from k[i-2] and k[i-1]
    function automatic t_word next_key(input t_word k2, input t_word k1, input logic z);
        t_word t;
        t = rotr(k1, 3) ^ rotr(k1, 4);
        next_key = ~k2 ^ t ^ {{(WORD_W-1){1'b0}}, z} ^ t_word'(3);
    endfunction

    function automatic t_word round_f(input t_word x, input t_word y, input t_word k);
        round_f = y ^ (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2) ^ k;
    endfunction

endpackage

@@ hdl/simon128_block_encrypt.sv @@
// SIMON-128/128 block encryption, one 128-bit block per item.
// Key: write key_word0 (index 0) and key_word1 (index 1) on the config port.
// Each write expands all 68 round keys into a 68 x 64 round key memory,
// one key per cycle, from the current values of both words;
// s_axis_tready stays low during that expansion.
// Input: s_axis_tdata carries the plaintext words, output m_axis_tdata the
// ciphertext words. An item runs one round per cycle, the last round holding
// while the output register cannot take the result. The first round key is
// read while idle; each later round key comes from a registered read issued
// the round before. The single round engine holds one item at a time and
// accepts the next only once it has finished all 68 rounds of the last.
// The next item is accepted as soon as the round engine is free, while the
// previous result still waits in the output register.
// If the receiver stalls, the finished round state holds at the last round
// until the output register frees.
// Reset clears both key words, the handshake state and the output valid;
// the round key memory holds nothing usable until the first key write.
module simon128_block_encrypt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [2*simon_pkg::WORD_W-1:0]   s_axis_tdata,  // x_in, y_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [2*simon_pkg::WORD_W-1:0]   m_axis_tdata,  // x_out, y_out
    input  logic                             i_cfg_we,
    input  logic [simon_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [simon_pkg::WORD_W-1:0]     i_cfg_wdata
);

    localparam simon_pkg::t_rnd LAST_RND = simon_pkg::t_rnd'(simon_pkg::NUM_ROUNDS - 1);
    localparam simon_pkg::t_rnd Z_LEN_R  = simon_pkg::t_rnd'(simon_pkg::Z_LEN);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state          r_state;
    simon_pkg::t_rnd r_rnd;
    simon_pkg::t_word r_x, r_y;
    simon_pkg::t_word r_xo, r_yo;
    logic            r_ov;

    simon_pkg::t_word r_key0, r_key1;
    simon_pkg::t_word r_ka, r_kb;
    simon_pkg::t_rnd r_widx;
    logic            r_exp;

    simon_pkg::t_word w_rkey;
    simon_pkg::t_word w_xn;
    simon_pkg::t_word w_knew;
    simon_pkg::t_word w_wdata;
    simon_pkg::t_rnd w_raddr;
    simon_pkg::t_rnd w_zd;
    logic [simon_pkg::Z_W-1:0] w_zidx;
    logic            w_cfg_hit;
    logic            w_in_acc;
    logic            w_out_free;
    logic            w_last;

    assign w_cfg_hit  = i_cfg_we && (i_cfg_idx == simon_pkg::REG_KEY_WORD0 ||
                                     i_cfg_idx == simon_pkg::REG_KEY_WORD1);
    assign s_axis_tready = (r_state == S_IDLE) && !r_exp;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ov || m_axis_tready;
    assign w_last     = (r_state == S_RUN) && (r_rnd == LAST_RND);

    always_comb begin
        w_zd = r_widx - simon_pkg::t_rnd'(2);
        if (w_zd >= Z_LEN_R) begin
            w_zd = w_zd - Z_LEN_R;
        end
        w_zidx = w_zd[simon_pkg::Z_W-1:0];
    end

    assign w_knew = simon_pkg::next_key(r_ka, r_kb, simon_pkg::Z2[w_zidx]);

    always_comb begin
        if (r_widx == simon_pkg::t_rnd'(0)) begin
            w_wdata = r_ka;
        end else if (r_widx == simon_pkg::t_rnd'(1)) begin
            w_wdata = r_kb;
        end else begin
            w_wdata = w_knew;
        end
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            w_raddr = '0;
        end else if (r_rnd == LAST_RND) begin
            w_raddr = r_rnd;
        end else begin
            w_raddr = r_rnd + simon_pkg::t_rnd'(1);
        end
    end

    simon_ram #(
        .WIDTH(simon_pkg::WORD_W),
        .DEPTH(simon_pkg::NUM_ROUNDS)
    ) u_rkey (
        .i_clk   (i_clk),
        .i_we    (r_exp),
        .i_waddr (r_widx),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rkey)
    );

    assign w_xn = simon_pkg::round_f(r_x, r_y, w_rkey);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_ov    <= 1'b0;
            r_exp   <= 1'b0;
            r_widx  <= '0;
            r_key0  <= '0;
            r_key1  <= '0;
        end else begin
            // key expansion
            if (w_cfg_hit) begin
                if (i_cfg_idx == simon_pkg::REG_KEY_WORD0) begin
                    r_key0 <= i_cfg_wdata;
                    r_ka   <= i_cfg_wdata;
                    r_kb   <= r_key1;
                end else begin
                    r_key1 <= i_cfg_wdata;
                    r_ka   <= r_key0;
                    r_kb   <= i_cfg_wdata;
                end
                r_widx <= '0;
                r_exp  <= 1'b1;
            end else if (r_exp) begin
                if (r_widx >= simon_pkg::t_rnd'(2)) begin
                    r_ka <= r_kb;
                    r_kb <= w_knew;
                end
                if (r_widx == LAST_RND) begin
                    r_exp <= 1'b0;
                end
                r_widx <= r_widx + simon_pkg::t_rnd'(1);
            end

            // output register
            if (w_last && w_out_free) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end

            // round engine
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x     <= s_axis_tdata[simon_pkg::WORD_W-1:0];
                        r_y     <= s_axis_tdata[2*simon_pkg::WORD_W-1:simon_pkg::WORD_W];
                        r_rnd   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_rnd != LAST_RND) begin
                        r_x   <= w_xn;
                        r_y   <= r_x;
                        r_rnd <= r_rnd + simon_pkg::t_rnd'(1);
                    end else if (w_out_free) begin
                        r_xo    <= w_xn;
                        r_yo    <= r_x;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_yo, r_xo};

`ifndef SYNTH
    a_round_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_rnd != LAST_RND) |=>
            (r_state == S_RUN && r_rnd == $past(r_rnd) + simon_pkg::t_rnd'(1)))
        else $error("round counter did not advance");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_RUN && r_rnd == '0))
        else $error("accepted item did not start at round zero");

    a_exp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp && r_widx == LAST_RND && !w_cfg_hit) |=> !r_exp)
        else $error("key expansion did not stop after the last key");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !$past(r_ov)) |-> $past(w_last && w_out_free))
        else $error("result appeared without a finished last round");

    a_no_accept_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp |-> !w_in_acc)
        else $error("item accepted during key expansion");
`endif

endmodule

@@ hdl/simon_ram.sv @@
module simon_ram #(
    parameter int WIDTH = simon_pkg::WORD_W,
    parameter int DEPTH = simon_pkg::NUM_ROUNDS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sim/simon_checker.sv @@
`timescale 1ns / 1ps

module simon_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [2*simon_pkg::WORD_W-1:0]      i_s_tdata,   // x_in, y_in
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [2*simon_pkg::WORD_W-1:0]      i_m_tdata,   // x_out, y_out
    input  logic                                i_cfg_we,
    input  logic [simon_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [simon_pkg::WORD_W-1:0]        i_cfg_wdata,
    output int                                  o_pending,
    output int                                  o_fail_count
);

    localparam int ROUNDS   = 68;
    localparam int Z_PERIOD = 62;
    localparam int MAX_SHOWN = 10;

    // z2 sequence, element j at index j
    localparam logic [0:Z_PERIOD-1] Z_SEQ =
        62'b10101111_01110000_00110100_10011000_10100001_00011111_10010110_110011;

    typedef logic [simon_pkg::WORD_W-1:0] t_word;

    typedef struct packed {
        t_word y;
        t_word x;
    } t_cipher_block;

    t_word         key_lo;
    t_word         key_hi;
    t_word         key_sched [ROUNDS];
    t_cipher_block ciphertext_q [$];
    int            fails;
    int            shown;

    function automatic t_word rol(input t_word v, input int unsigned s);
        rol = (v << s) | (v >> (simon_pkg::WORD_W - s));
    endfunction

    function automatic t_word ror(input t_word v, input int unsigned s);
        ror = (v >> s) | (v << (simon_pkg::WORD_W - s));
    endfunction

    function automatic void expand_round_keys();
        key_sched[0] = key_lo;
        key_sched[1] = key_hi;
        for (int i = 2; i < ROUNDS; i++) begin
            key_sched[i] = ~key_sched[i-2] ^ ror(key_sched[i-1], 3)
                         ^ ror(key_sched[i-1], 4)
                         ^ t_word'(Z_SEQ[(i-2) % Z_PERIOD]) ^ t_word'(3);
        end
    endfunction

    function automatic t_cipher_block encipher(input t_word x, input t_word y);
        t_word         prev;
        t_cipher_block blk;
        for (int i = 0; i < ROUNDS; i++) begin
            prev = x;
            x = y ^ (rol(x, 1) & rol(x, 8)) ^ rol(x, 2) ^ key_sched[i];
            y = prev;
        end
        blk.x = x;
        blk.y = y;
        return blk;
    endfunction

    always @(posedge i_clk) begin
        t_cipher_block want;
        t_cipher_block got;
        if (!i_rst_n) begin
            key_lo = '0;
            key_hi = '0;
            for (int i = 0; i < ROUNDS; i++) key_sched[i] = '0;
            ciphertext_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == simon_pkg::REG_KEY_WORD0) begin
                    key_lo = i_cfg_wdata;
                    expand_round_keys();
                end else if (i_cfg_idx == simon_pkg::REG_KEY_WORD1) begin
                    key_hi = i_cfg_wdata;
                    expand_round_keys();
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                ciphertext_q.push_back(
                    encipher(i_s_tdata[simon_pkg::WORD_W-1:0],
                             i_s_tdata[2*simon_pkg::WORD_W-1:simon_pkg::WORD_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (ciphertext_q.size() == 0) begin
                    fails++;
                    if (shown < MAX_SHOWN) begin
                        shown++;
                        $display("unexpected item: x_out %h y_out %h", got.x, got.y);
                    end
                end else begin
                    want = ciphertext_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y) begin
                        fails++;
                        if (shown < MAX_SHOWN) begin
                            shown++;
                            $display("mismatch: x_out exp %h got %h, y_out exp %h got %h",
                                     want.x, got.x, want.y, got.y);
                        end
                    end
                end
            end
        end
        o_pending <= ciphertext_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    typedef logic [simon_pkg::WORD_W-1:0] t_word;

    localparam logic [simon_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [simon_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;
    localparam t_word ALL_ONES = '1;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [2*simon_pkg::WORD_W-1:0]      s_axis_tdata;   // x_in, y_in
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [2*simon_pkg::WORD_W-1:0]      m_axis_tdata;   // x_out, y_out
    logic                                i_cfg_we;
    logic [simon_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [simon_pkg::WORD_W-1:0]        i_cfg_wdata;

    int pending;
    int fail_count;
    bit steady;
    int hold_left;

    simon128_block_encrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    simon_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // stall the result side now and then, sometimes long enough to hold the engine
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(199) == 0) begin
            hold_left <= $urandom_range(59);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic t_word rand_word();
        t_word w;
        w = {$urandom, $urandom};
        case ($urandom_range(15))
            0: w = t_word'(1) << $urandom_range(63);
            1: w = ~(t_word'(1) << $urandom_range(63));
            default: ;
        endcase
        return w;
    endfunction

    task automatic write_reg(input logic [simon_pkg::CFG_IDX_W-1:0] idx, input t_word val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // hold off until the round key expansion is done
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic push_block(input t_word x, input t_word y);
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++) push_block(rand_word(), rand_word());
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        steady = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // key word one left at its reset value
        write_reg(simon_pkg::REG_KEY_WORD0, rand_word());
        push_block('0, '0);
        push_block(ALL_ONES, ALL_ONES);
        push_block('0, ALL_ONES);
        push_block(ALL_ONES, '0);
        push_block(64'h8000_0000_0000_0000, 64'h1);
        push_block(64'h1, 64'h8000_0000_0000_0000);
        push_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        push_random(150);
        drain();

        write_reg(simon_pkg::REG_KEY_WORD0, '0);
        write_reg(simon_pkg::REG_KEY_WORD1, '0);
        push_random(150);
        drain();

        steady = 1'b1;
        write_reg(simon_pkg::REG_KEY_WORD0, ALL_ONES);
        write_reg(simon_pkg::REG_KEY_WORD1, ALL_ONES);
        push_random(250);
        drain();
        steady = 1'b0;

        write_reg(simon_pkg::REG_KEY_WORD0, 64'h0706_0504_0302_0100);
        write_reg(simon_pkg::REG_KEY_WORD1, 64'h0f0e_0d0c_0b0a_0908);
        push_block(64'h6373_6564_2073_7265, 64'h6c6c_6576_6172_7420);
        push_random(100);
        drain();

        // only key word one changes; spare indexes must leave the keys alone
        write_reg(simon_pkg::REG_KEY_WORD1, rand_word());
        write_reg(CFG_IDX_SPARE2, rand_word());
        write_reg(CFG_IDX_SPARE3, rand_word());
        push_random(150);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p % 2 == 0) begin
                write_reg(simon_pkg::REG_KEY_WORD0, rand_word());
                write_reg(simon_pkg::REG_KEY_WORD1, rand_word());
            end else begin
                write_reg(simon_pkg::REG_KEY_WORD1, rand_word());
                write_reg(simon_pkg::REG_KEY_WORD0, rand_word());
            end
            push_random(130);
            drain();
        end

        repeat (80) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
